@@ rtl/core/fbds_pkg.sv @@
// Package for the four-button debounced scanner.
// Holds the phase encoding, result type and reset constants; no dependencies.
`default_nettype none

package fbds_pkg;

  localparam int unsigned NUM_BUTTONS = 4;
  localparam int unsigned BTN_IDX_W   = 2;
  localparam int unsigned TICK_W      = 8;

  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 8'd30;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_PRESS_WAIT   = 2'd1,
    PH_HELD         = 2'd2,
    PH_RELEASE_WAIT = 2'd3
  } phase_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] lamps;
    logic                   event_valid;
    logic [BTN_IDX_W-1:0]   event_button;
  } result_t;

endpackage : fbds_pkg

`default_nettype wire

@@ rtl/core/fbds_if.sv @@
// Handshake channel interfaces for the four-button debounced scanner.
// Depends on fbds_pkg for field widths.
`default_nettype none

interface fbds_in_if;
  import fbds_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] buttons_n;

  modport source (output valid, output buttons_n, input ready);
  modport sink   (input valid, input buttons_n, output ready);
endinterface : fbds_in_if

interface fbds_out_if;
  import fbds_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] lamps;
  logic                   event_valid;
  logic [BTN_IDX_W-1:0]   event_button;

  modport source (output valid, output lamps, output event_valid, output event_button,
                  input ready);
  modport sink   (input valid, input lamps, input event_valid, input event_button,
                  output ready);
endinterface : fbds_out_if

interface fbds_cfg_if;
  import fbds_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] debounce_ms;

  modport source (output valid, output debounce_ms, input ready);
  modport sink   (input valid, input debounce_ms, output ready);
endinterface : fbds_cfg_if

`default_nettype wire

@@ rtl/core/fbds_fsm.sv @@
// Debounce state machine: phase, chosen button and tick counter.
// Depends on fbds_pkg; advances one tick each cycle that step is high.
`default_nettype none

module fbds_fsm
  import fbds_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [NUM_BUTTONS-1:0] buttons_n,
  input  wire logic [TICK_W-1:0]      debounce_ms,
  output result_t                     res
);

  phase_t                 phase_r, phase_nxt;
  logic [BTN_IDX_W-1:0]   chosen_r, chosen_nxt;
  logic [TICK_W-1:0]      elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0]      elapsed_inc;
  logic                   wait_done;
  logic                   chosen_held;
  logic                   any_held;
  logic [BTN_IDX_W-1:0]   first_held;
  logic                   evt;

  assign elapsed_inc = elapsed_r + TICK_W'(1);
  assign wait_done   = (elapsed_inc >= debounce_ms);
  assign chosen_held = ~buttons_n[chosen_r];
  assign any_held    = ~(&buttons_n);

  // Fixed priority: green, white, blue, red.
  always_comb begin
    first_held = BTN_IDX_W'(3);
    if (!buttons_n[0]) begin
      first_held = BTN_IDX_W'(0);
    end else if (!buttons_n[1]) begin
      first_held = BTN_IDX_W'(1);
    end else if (!buttons_n[2]) begin
      first_held = BTN_IDX_W'(2);
    end
  end

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    chosen_nxt  = chosen_r;
    elapsed_nxt = elapsed_r;
    evt         = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (any_held) begin
          chosen_nxt  = first_held;
          elapsed_nxt = '0;
          phase_nxt   = PH_PRESS_WAIT;
        end
      end
      PH_PRESS_WAIT: begin
        elapsed_nxt = elapsed_inc;
        if (wait_done) begin
          phase_nxt = chosen_held ? PH_HELD : PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!chosen_held) begin
          elapsed_nxt = '0;
          phase_nxt   = PH_RELEASE_WAIT;
        end
      end
      PH_RELEASE_WAIT: begin
        elapsed_nxt = elapsed_inc;
        if (wait_done) begin
          evt       = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Outputs reflect the state after this tick.
  always_comb begin
    res.lamps        = '0;
    res.event_valid  = evt;
    res.event_button = evt ? chosen_r : '0;
    if (phase_nxt == PH_HELD || phase_nxt == PH_RELEASE_WAIT) begin
      res.lamps[chosen_nxt] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      chosen_r  <= '0;
      elapsed_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      chosen_r  <= chosen_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule : fbds_fsm

`default_nettype wire

@@ rtl/core/four_button_debounced_scanner.sv @@
// Top level of the four-button debounced scanner.
// Depends on fbds_pkg, the fbds_*_if interfaces and fbds_fsm.
//
// Usage:
//  - in_ch carries one millisecond tick per transfer: the raw active-low
//    levels of four buttons (bit0 green, bit1 white, bit2 blue, bit3 red).
//  - out_ch returns exactly one result per tick: lamp drive, and a one-tick
//    event flag with the button index when a debounced press and release
//    completes.
//  - cfg_ch writes debounce_ms, the settling wait in ticks; cfg_ch.ready is
//    always high. Write it only while no tick is in flight.
//  - An input transfer passes through the input register and then the result
//    register before its result can transfer out.
//    One tick is taken every cycle while out_ch does not stall; the state
//    update is a single compare and increment between the two registers.
//  - Reset (rst_n low, synchronous) returns to idle scanning with lamps off,
//    clears both stage valids and loads debounce_ms with 30.
//  - When out_ch stalls, the result holds in the output register and the
//    input register holds its tick; in_ch.ready drops only once both are full.
`default_nettype none

module four_button_debounced_scanner
  import fbds_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  fbds_in_if.sink     in_ch,
  fbds_out_if.source  out_ch,
  fbds_cfg_if.sink    cfg_ch
);

  logic [TICK_W-1:0]      debounce_r;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [NUM_BUTTONS-1:0] s1_buttons_r;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_res_r;
  result_t                step_res;
  logic                   in_xfer;
  logic                   advance;

  // Advance the held tick when the result register is free or being drained.
  assign advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_ch.valid) begin
      debounce_r <= cfg_ch.debounce_ms;
    end
  end

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_buttons_r <= in_ch.buttons_n;
    end
  end

  // State update for the tick in the input register
  fbds_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .buttons_n   (s1_buttons_r),
    .debounce_ms (debounce_r),
    .res         (step_res)
  );

  // Result register: load on advance, drop on transfer out.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.lamps        = out_res_r.lamps;
  assign out_ch.event_valid  = out_res_r.event_valid;
  assign out_ch.event_button = out_res_r.event_button;

endmodule : four_button_debounced_scanner

`default_nettype wire

@@ tb/sv/four_button_debounced_scanner_tb.sv @@
// Testbench for the four-button debounced scanner: directed and random tick streams.
// Predicts every result in a local scan model and checks it field by field.
// Depends on fbds_pkg, the fbds_*_if interfaces and the scanner RTL.
`timescale 1ns / 100ps

module four_button_debounced_scanner_tb;
  import fbds_pkg::*;

  // Allow well above the slowest correct run, even at the worst idling.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Two register stages, plus margin, before the block counts as settled.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk;
  logic rst_n;

  fbds_in_if  in_if ();
  fbds_out_if out_if ();
  fbds_cfg_if cfg_if ();

  four_button_debounced_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // 2 ns period: high for 1 ns, low for 1 ns.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scan model: a copy of the block's state, advanced once per accepted tick.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0]    settle_ms    = DEBOUNCE_RESET;
  phase_t               scan_phase   = PH_IDLE;
  logic [BTN_IDX_W-1:0] scan_btn     = '0;
  logic [TICK_W-1:0]    settle_count = '0;

  // Results predicted for accepted ticks, oldest first.
  result_t pending_scans[$];

  int unsigned mismatch_count = 0;
  int unsigned ticks_sent     = 0;
  int unsigned cycle_count    = 0;

  // Idling odds in percent, changed by the test tasks.
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;

  // Long receiver hold-off, requested by a test and counted in its own process.
  event        hold_go;
  int unsigned hold_cycles = 0;
  logic        out_hold    = 1'b0;

  // Advance the scan model by one tick and return the result it produces.
  function automatic result_t debounce_tick(input logic [NUM_BUTTONS-1:0] levels_n);
    result_t r;
    bit      found;
    r     = '0;
    found = 1'b0;
    case (scan_phase)
      PH_IDLE: begin
        // Take the first pressed button in priority order green, white, blue, red.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (!found && !levels_n[b]) begin
            found        = 1'b1;
            scan_btn     = BTN_IDX_W'(b);
            settle_count = '0;
            scan_phase   = PH_PRESS_WAIT;
          end
        end
      end
      PH_PRESS_WAIT: begin
        // A zero setting compares as done on the first counted tick.
        settle_count = settle_count + 1'b1;
        if (settle_count >= settle_ms)
          scan_phase = levels_n[scan_btn] ? PH_IDLE : PH_HELD;
      end
      PH_HELD: begin
        if (levels_n[scan_btn]) begin
          settle_count = '0;
          scan_phase   = PH_RELEASE_WAIT;
        end
      end
      PH_RELEASE_WAIT: begin
        settle_count = settle_count + 1'b1;
        if (settle_count >= settle_ms) begin
          r.event_valid  = 1'b1;
          r.event_button = scan_btn;
          scan_phase     = PH_IDLE;
        end
      end
      default: scan_phase = PH_IDLE;
    endcase
    // Light the chosen lamp while held and while the release settles.
    if (scan_phase == PH_HELD || scan_phase == PH_RELEASE_WAIT)
      r.lamps = NUM_BUTTONS'(1) << scan_btn;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, long hold-off, and the checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_if.ready <= !out_hold && ($urandom_range(0, 99) >= out_stall_pct);
  end

  initial begin
    forever begin
      @(hold_go);
      out_hold <= 1'b1;
      repeat (hold_cycles) @(negedge clk);
      out_hold <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_scans.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: lamps=%h event_valid=%b event_button=%0d",
                 $time, out_if.lamps, out_if.event_valid, out_if.event_button);
      end else begin
        want = pending_scans.pop_front();
        if (out_if.lamps !== want.lamps) begin
          mismatch_count++;
          $display("%0t: lamps mismatch: expected %h, actual %h",
                   $time, want.lamps, out_if.lamps);
        end
        if (out_if.event_valid !== want.event_valid) begin
          mismatch_count++;
          $display("%0t: event_valid mismatch: expected %b, actual %b",
                   $time, want.event_valid, out_if.event_valid);
        end
        if (out_if.event_button !== want.event_button) begin
          mismatch_count++;
          $display("%0t: event_button mismatch: expected %0d, actual %0d",
                   $time, want.event_button, out_if.event_button);
        end
      end
    end
  end

  // End the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("four_button_debounced_scanner_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: shared drivers.
  // ---------------------------------------------------------------------------

  // Offer one tick, idling first at random; predict its result on transfer.
  task automatic send_tick(input logic [NUM_BUTTONS-1:0] levels_n);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.buttons_n <= levels_n;
    do @(posedge clk); while (!in_if.ready);
    pending_scans.push_back(debounce_tick(levels_n));
    ticks_sent++;
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_results_done();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write debounce_ms; call only with the block idle.
  task automatic write_debounce(input logic [TICK_W-1:0] value);
    @(negedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.debounce_ms <= value;
    do @(posedge clk); while (!cfg_if.ready);
    settle_ms = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // One press-and-release of a random button, with bounce inside both waits.
  // With may_abort, sometimes release exactly at the press check instead.
  task automatic send_episode(input bit may_abort);
    int unsigned            dwell;
    int unsigned            btn;
    int unsigned            hold_extra;
    int unsigned            i;
    bit                     abort;
    logic [NUM_BUTTONS-1:0] lv;
    dwell      = (settle_ms == 0) ? 1 : settle_ms;
    btn        = $urandom_range(0, NUM_BUTTONS - 1);
    abort      = may_abort && ($urandom_range(0, 7) == 0);
    hold_extra = abort ? 0 : $urandom_range(0, 5);
    // Press edge: keep higher-priority buttons released so this one wins.
    lv = NUM_BUTTONS'($urandom);
    for (i = 0; i < btn; i++) lv[i] = 1'b1;
    lv[btn] = 1'b0;
    send_tick(lv);
    // Bounce freely until the check tick.
    for (i = 1; i < dwell; i++) send_tick(NUM_BUTTONS'($urandom));
    // Check tick, then hold; an abort releases right at the check.
    for (i = 0; i <= hold_extra; i++) begin
      lv      = NUM_BUTTONS'($urandom);
      lv[btn] = abort;
      send_tick(lv);
    end
    if (!abort) begin
      lv      = NUM_BUTTONS'($urandom);
      lv[btn] = 1'b1;
      send_tick(lv);
      // Release settles; noise here is ignored and the last tick reports.
      for (i = 1; i <= dwell; i++) send_tick(NUM_BUTTONS'($urandom));
    end
    repeat ($urandom_range(0, 3)) send_tick('1);
  endtask

  // A burst of raw random levels, then enough released ticks to get back to idle.
  task automatic send_noise();
    int unsigned dwell;
    dwell = (settle_ms == 0) ? 1 : settle_ms;
    repeat ($urandom_range(1, 6)) send_tick(NUM_BUTTONS'($urandom));
    repeat (2 * dwell + 2) send_tick('1);
  endtask

  function automatic logic [TICK_W-1:0] pick_debounce();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 8'd1;
      default: return TICK_W'($urandom_range(2, 9));
    endcase
  endfunction

  // Mostly well-formed episodes, some noise, with occasional new settings.
  task automatic run_mix(input int unsigned n_ticks);
    int unsigned stop_at;
    stop_at = ticks_sent + n_ticks;
    wait_results_done();
    write_debounce(pick_debounce());
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0)
        send_noise();
      else
        send_episode(1'b1);
      if ($urandom_range(0, 5) == 0) begin
        wait_results_done();
        write_debounce(pick_debounce());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run one full episode on the reset setting of 30 ticks.
  task automatic test_reset_debounce();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_episode(1'b0);
  endtask

  // Zero setting acts as one tick: walk every button, the all-pressed and
  // all-released extremes, a release at the press check and bounce in both waits.
  task automatic test_directed_zero_debounce();
    logic [NUM_BUTTONS-1:0] seq [20];
    seq = '{4'hF, 4'h7, 4'h7, 4'hF, 4'h0, 4'h0, 4'hF, 4'hB, 4'h0, 4'h0,
            4'h4, 4'hF, 4'hD, 4'hD, 4'hF, 4'hF, 4'hE, 4'hE, 4'hF, 4'hF};
    wait_results_done();
    write_debounce('0);
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  task automatic test_shortest_debounce();
    wait_results_done();
    write_debounce(8'd1);
    repeat (6) send_episode(1'b1);
  endtask

  // Longest setting: one complete episode of about 520 ticks.
  task automatic test_longest_debounce();
    wait_results_done();
    write_debounce(8'hFF);
    send_episode(1'b0);
  endtask

  task automatic test_no_idling();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_mix(200);
  endtask

  task automatic test_sender_gaps();
    in_idle_pct   = 68;
    out_stall_pct = 0;
    run_mix(200);
  endtask

  task automatic test_receiver_stalls();
    in_idle_pct   = 0;
    out_stall_pct = 68;
    run_mix(200);
  endtask

  task automatic test_both_idle();
    in_idle_pct   = 31;
    out_stall_pct = 31;
    run_mix(200);
  endtask

  // Hold the receiver off long enough to fill both stages and stall the input,
  // then pause the sender until everything has drained.
  task automatic test_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    wait_results_done();
    write_debounce(8'd2);
    repeat (2) begin
      hold_cycles = 40;
      @(negedge clk);
      -> hold_go;
      repeat (4) send_episode(1'b1);
      wait_results_done();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.buttons_n    = '1;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.debounce_ms = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_debounce();
    test_directed_zero_debounce();
    test_shortest_debounce();
    test_longest_debounce();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();

    wait_results_done();
    if (pending_scans.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("four_button_debounced_scanner_tb: done, clean");
    end else begin
      $display("four_button_debounced_scanner_tb: done, errors");
    end
    $finish;
  end

endmodule : four_button_debounced_scanner_tb

@@ four_button_debounced_scanner.f @@
rtl/core/fbds_pkg.sv
rtl/core/fbds_if.sv
rtl/core/fbds_fsm.sv
rtl/core/four_button_debounced_scanner.sv
tb/sv/four_button_debounced_scanner_tb.sv
